// ===== rtl/gzls_pkg.sv =====
// Shared types, constants and codes for the grid zone layer selector.
package gzls_pkg;

    localparam int COLUMNS_DEF = 3;
    localparam int ROWS_DEF    = 3;
    localparam int PAD_MAX_DEF = 1024;

    localparam logic [15:0] HOLD_RESET       = 16'd512;
    localparam logic [7:0]  BASE_LAYER_RESET = 8'd6;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd80;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_X     = 2'd0,
        KIND_Y     = 2'd1,
        KIND_OTHER = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    localparam logic ACT_DEACTIVATE = 1'b0;
    localparam logic ACT_ACTIVATE   = 1'b1;

    localparam logic REG_BASE_LAYER = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    // two: deactivate old_layer first, then apply action to layer
    typedef struct packed {
        logic       two;
        logic       action;
        logic [7:0] layer;
        logic [7:0] old_layer;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

endpackage

// ===== rtl/gzls_front.sv =====
// Front end: input acceptance, layer state, watchdog and command generation.
module gzls_front
    import gzls_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    parameter int PAD_MAX = PAD_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [1:0]  kind,
    input  logic [15:0] coord_value,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam int X_SIZE = PAD_MAX / COLUMNS;
    localparam int Y_SIZE = PAD_MAX / ROWS;

    logic [7:0]  base_layer_reg;
    logic [15:0] timeout_reg;
    logic [15:0] held_x_reg, held_x_next;
    logic [15:0] held_y_reg, held_y_next;
    logic [7:0]  cur_layer_reg, cur_layer_next;
    logic        layer_on_reg, layer_on_next;
    logic [15:0] countdown_reg, countdown_next;
    logic        armed_reg, armed_next;

    logic        accept;
    kind_t       kind_e;
    logic [7:0]  col_idx;
    logic [7:0]  row_idx;
    logic [7:0]  target;
    logic [15:0] cd_dec;

    assign accept = push && !q_full;
    assign kind_e = kind_t'(kind);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_layer_reg <= BASE_LAYER_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_LAYER: base_layer_reg <= cfg_data[7:0];
                REG_TIMEOUT:    timeout_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        held_x_next = (kind_e == KIND_X) ? coord_value : held_x_reg;
        held_y_next = (kind_e == KIND_Y) ? coord_value : held_y_reg;
    end

    // thresholds never exceed PAD_MAX, so a coordinate past the pad counts as the last cell
    always_comb
    begin
        col_idx = '0;
        for (int k = 1; k < COLUMNS; k++)
        begin
            if (X_SIZE != 0 && {1'b0, held_x_next} >= 17'(k * X_SIZE))
            begin
                col_idx = col_idx + 8'd1;
            end
        end
    end

    always_comb
    begin
        row_idx = '0;
        for (int k = 1; k < ROWS; k++)
        begin
            if (Y_SIZE != 0 && {1'b0, held_y_next} >= 17'(k * Y_SIZE))
            begin
                row_idx = row_idx + 8'd1;
            end
        end
    end

    assign target = base_layer_reg + 8'(row_idx * COLUMNS) + col_idx;
    assign cd_dec = (countdown_reg != '0) ? countdown_reg - 16'd1 : countdown_reg;

    always_comb
    begin
        cur_layer_next   = cur_layer_reg;
        layer_on_next    = layer_on_reg;
        countdown_next   = countdown_reg;
        armed_next       = armed_reg;
        q_push           = 1'b0;
        q_cmd.two        = 1'b0;
        q_cmd.action     = ACT_ACTIVATE;
        q_cmd.layer      = target;
        q_cmd.old_layer  = cur_layer_reg;
        unique case (kind_e)
            KIND_X, KIND_Y:
            begin
                if (!layer_on_reg || cur_layer_reg != target)
                begin
                    q_push         = accept;
                    q_cmd.two      = layer_on_reg;
                    cur_layer_next = target;
                    layer_on_next  = 1'b1;
                end
                countdown_next = timeout_reg;
                armed_next     = 1'b1;
            end
            KIND_TICK:
            begin
                if (armed_reg)
                begin
                    countdown_next = cd_dec;
                    if (cd_dec == '0)
                    begin
                        armed_next = 1'b0;
                        if (layer_on_reg)
                        begin
                            q_push        = accept;
                            q_cmd.action  = ACT_DEACTIVATE;
                            q_cmd.layer   = cur_layer_reg;
                            layer_on_next = 1'b0;
                        end
                    end
                end
            end
            KIND_OTHER: ;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg    <= HOLD_RESET;
            held_y_reg    <= HOLD_RESET;
            cur_layer_reg <= BASE_LAYER_RESET;
            layer_on_reg  <= 1'b0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
        end
        else if (accept)
        begin
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            cur_layer_reg <= cur_layer_next;
            layer_on_reg  <= layer_on_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

// ===== rtl/gzls_queue.sv =====
// Command queue between the front end and the result sequencer.
module gzls_queue
    import gzls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   cmd_in,
    input  logic   deq,
    output logic   full,
    output qhead_t head
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_deq;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_deq     = deq && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_deq})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/gzls_back.sv =====
// Result sequencer: expands each queued command into one or two result beats.
module gzls_back
    import gzls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qhead_t     head,
    input  logic       pop,
    output logic       deq,
    output logic       empty,
    output logic       action,
    output logic [7:0] layer_number,
    output logic       last_of_run
);

    logic phase_reg, phase_next;
    logic first_of_two;
    logic beat;

    assign first_of_two = head.cmd.two && !phase_reg;
    assign empty        = !head.valid;
    assign beat         = pop && head.valid;
    assign action       = first_of_two ? ACT_DEACTIVATE : head.cmd.action;
    assign layer_number = first_of_two ? head.cmd.old_layer : head.cmd.layer;
    assign last_of_run  = !first_of_two;
    assign deq          = beat && !first_of_two;

    always_comb
    begin
        phase_next = phase_reg;
        if (beat)
        begin
            phase_next = first_of_two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== rtl/grid_zone_layer_selector_core.sv =====
// Top level of the grid zone layer selector.
//
//  channel   | ports                                   | beat taken when
//  ----------+-----------------------------------------+-------------------
//  input     | push, full, kind, coord_value           | push && !full
//  result    | empty, pop, action, layer_number,       | pop && !empty
//            | last_of_run                             |
//  config    | cfg_we, cfg_index, cfg_data             | cfg_we
//
//  One input beat per cycle while full is low; an item is classified and the layer and watchdog
//  state updated in the cycle it is taken.
//  A four-entry command queue sits between front and sequencer; full rises when
//  four commands wait, and a layer change takes two result beats to drain.
//  A result appears on the ports the cycle after its input beat at the earliest.
//  Reset loads all state but the queue slots at once; no clearing pass.
module grid_zone_layer_selector_core
    import gzls_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    parameter int PAD_MAX = PAD_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] coord_value,
    output logic        empty,
    input  logic        pop,
    output logic        action,
    output logic [7:0]  layer_number,
    output logic        last_of_run,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic   q_push;
    cmd_t   q_cmd;
    logic   q_full;
    logic   q_deq;
    qhead_t q_head;

    assign full = q_full;

    gzls_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .PAD_MAX (PAD_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .kind        (kind),
        .coord_value (coord_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    gzls_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .cmd_in (q_cmd),
        .deq    (q_deq),
        .full   (q_full),
        .head   (q_head)
    );

    gzls_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .pop          (pop),
        .deq          (q_deq),
        .empty        (empty),
        .action       (action),
        .layer_number (layer_number),
        .last_of_run  (last_of_run)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command pushed into full queue");

    a_first_beat_deact: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_of_run) |-> (action == ACT_DEACTIVATE))
        else $error("non-final beat is not a deactivate");

    a_second_beat_act: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_of_run) |=>
            (!empty && last_of_run && action == ACT_ACTIVATE))
        else $error("deactivate beat not followed by activate");

    a_tick_single: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && kind == KIND_TICK) |-> (!q_cmd.two && q_cmd.action == ACT_DEACTIVATE))
        else $error("tick produced a layer change command");
`endif

endmodule

// ===== test/grid_zone_layer_selector_core_test.sv =====
// Self-checking testbench for the layer selector core: directed, random and backpressure runs.
module grid_zone_layer_selector_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gzls_pkg::*;

    typedef struct {
        logic       action;
        logic [7:0] layer;
        logic       last;
    } layer_event_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  kind;
    logic [15:0] coord_value;
    logic        empty;
    logic        pop;
    logic        action;
    logic [7:0]  layer_number;
    logic        last_of_run;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    layer_event_t pending_events[$];
    int           error_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;

    logic [7:0]  base_layer_q;
    logic [15:0] timeout_q;
    logic [15:0] held_x;
    logic [15:0] held_y;
    logic [7:0]  cur_layer;
    logic        layer_on;
    logic [15:0] countdown;
    logic        armed;

    grid_zone_layer_selector_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .coord_value  (coord_value),
        .empty        (empty),
        .pop          (pop),
        .action       (action),
        .layer_number (layer_number),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned cell_on_axis(logic [15:0] v, int unsigned cells);
        int unsigned pos;
        int unsigned size;
        int unsigned idx;
        pos  = (v > PAD_MAX_DEF) ? PAD_MAX_DEF : v;
        size = PAD_MAX_DEF / cells;
        if (size == 0)
            return 0;
        idx = pos / size;
        if (idx > cells - 1)
            idx = cells - 1;
        return idx;
    endfunction

    function automatic void queue_event(logic act, logic [7:0] layer);
        layer_event_t ev;
        ev.action = act;
        ev.layer  = layer;
        ev.last   = 1'b0;
        pending_events.push_back(ev);
    endfunction

    // Update the tracked selector state for one accepted beat; queue its results.
    function automatic void track_selection(kind_t k, logic [15:0] v);
        int          first;
        logic [7:0]  target;
        int unsigned col;
        int unsigned row;
        first = pending_events.size();
        if (k == KIND_X || k == KIND_Y)
        begin
            if (k == KIND_X)
                held_x = v;
            else
                held_y = v;
            col    = cell_on_axis(held_x, COLUMNS_DEF);
            row    = cell_on_axis(held_y, ROWS_DEF);
            target = base_layer_q + 8'(row * COLUMNS_DEF + col);
            if (!layer_on || cur_layer != target)
            begin
                if (layer_on)
                    queue_event(ACT_DEACTIVATE, cur_layer);
                queue_event(ACT_ACTIVATE, target);
                cur_layer = target;
                layer_on  = 1'b1;
            end
            countdown = timeout_q;
            armed     = 1'b1;
        end
        else if (k == KIND_TICK && armed)
        begin
            if (countdown != 0)
                countdown = countdown - 16'd1;
            if (countdown == 0)
            begin
                armed = 1'b0;
                if (layer_on)
                begin
                    queue_event(ACT_DEACTIVATE, cur_layer);
                    layer_on = 1'b0;
                end
            end
        end
        if (pending_events.size() > first)
            pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    task automatic send_beat(kind_t k, logic [15:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push        = 1'b1;
        kind        = k;
        coord_value = v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        track_selection(k, v);
    endtask

    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        if (idx == REG_BASE_LAYER)
            base_layer_q = data[7:0];
        else
            timeout_q = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_coord();
        logic [15:0] edges[9] = '{16'd0, 16'd340, 16'd341, 16'd682, 16'd683,
                                   16'd1023, 16'd1024, 16'd1025, 16'hFFFF};
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return edges[$urandom_range(8)];
            default: return 16'($urandom_range(1100));
        endcase
    endfunction

    task automatic test_cell_grid();
        send_beat(KIND_TICK, 16'd0);
        send_beat(KIND_OTHER, 16'hFFFF);
        send_beat(KIND_X, 16'd0);
        send_beat(KIND_Y, 16'd0);
        send_beat(KIND_X, 16'd340);
        send_beat(KIND_X, 16'd341);
        send_beat(KIND_X, 16'hFFFF);
        send_beat(KIND_Y, 16'd683);
        send_beat(KIND_Y, 16'd1024);
        send_beat(KIND_X, 16'd682);
        send_beat(KIND_OTHER, 16'd0);
        send_beat(KIND_Y, 16'd1025);
        settle();
    endtask

    task automatic test_watchdog();
        write_reg(REG_TIMEOUT, 16'd2);
        write_reg(REG_BASE_LAYER, 16'hAAFF);
        send_beat(KIND_X, 16'd1024);
        send_beat(KIND_TICK, 16'd0);
        send_beat(KIND_X, 16'd1000);
        send_beat(KIND_TICK, 16'd0);
        send_beat(KIND_TICK, 16'd0);
        send_beat(KIND_TICK, 16'd0);
        settle();
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_BASE_LAYER, 16'h5500);
        send_beat(KIND_Y, 16'd0);
        send_beat(KIND_TICK, 16'hFFFF);
        settle();
        write_reg(REG_TIMEOUT, 16'hFFFF);
        send_beat(KIND_X, 16'd0);
        send_beat(KIND_TICK, 16'd0);
        settle();
    endtask

    task automatic test_random_traffic(int s_idle, int r_stall, int count,
                                       logic [7:0] base, logic [15:0] tmo);
        int sel;
        write_reg(REG_BASE_LAYER, {8'($urandom), base});
        write_reg(REG_TIMEOUT, tmo);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(9);
            if (sel <= 2)
                send_beat(KIND_X, pick_coord());
            else if (sel <= 5)
                send_beat(KIND_Y, pick_coord());
            else if (sel == 6)
                send_beat(KIND_OTHER, 16'($urandom));
            else
                send_beat(KIND_TICK, 16'($urandom));
        end
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_TIMEOUT, 16'd3);
        @(posedge clk);
        hold_left = 200;
        for (int n = 0; n < 30; n++)
            send_beat((n % 2) ? KIND_Y : KIND_X, (n % 4 < 2) ? 16'd0 : 16'd1024);
        settle();
    endtask

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                pop       = 1'b0;
                hold_left = hold_left - 1;
            end
            else
                pop = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        layer_event_t ev;
        if (rst_n && pop && !empty)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected result action %0d layer %0d last %0d",
                         $time, action, layer_number, last_of_run);
                error_count++;
            end
            else
            begin
                ev = pending_events.pop_front();
                if (action !== ev.action)
                begin
                    $display("%0t: action expected %0d got %0d", $time, ev.action, action);
                    error_count++;
                end
                if (layer_number !== ev.layer)
                begin
                    $display("%0t: layer_number expected %0d got %0d",
                             $time, ev.layer, layer_number);
                    error_count++;
                end
                if (last_of_run !== ev.last)
                begin
                    $display("%0t: last_of_run expected %0d got %0d",
                             $time, ev.last, last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        kind           = KIND_OTHER;
        coord_value    = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_BASE_LAYER;
        cfg_data       = '0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        base_layer_q   = BASE_LAYER_RESET;
        timeout_q      = TIMEOUT_RESET;
        held_x         = HOLD_RESET;
        held_y         = HOLD_RESET;
        cur_layer      = BASE_LAYER_RESET;
        layer_on       = 1'b0;
        countdown      = '0;
        armed          = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_cell_grid();
        test_watchdog();
        test_random_traffic(0, 0, 190, 8'($urandom), 16'($urandom_range(1, 6)));
        test_random_traffic(69, 0, 190, 8'd255, 16'($urandom_range(1, 10)));
        test_random_traffic(0, 69, 190, 8'd0, 16'($urandom));
        test_random_traffic(9, 9, 190, 8'($urandom), 16'd1);
        test_backpressure();

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
